[rtl/nested_scope_end_finder_assert.svh]
`ifndef NESTED_SCOPE_END_FINDER_ASSERT_SVH
`define NESTED_SCOPE_END_FINDER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define NSEF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NSEF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/nsef_pkg.sv]
package nsef_pkg;

  typedef enum logic [2:0] {
    ST_SCAN     = 3'd0,
    ST_CLOSED   = 3'd1,
    ST_ENDED    = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_BADOPEN  = 3'd4,
    ST_IDLE     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    SC_DQ = 2'd0,
    SC_SQ = 2'd1,
    SC_BT = 2'd2,
    SC_BR = 2'd3
  } scope_e;

  typedef enum logic [1:0] {
    SKIP_NONE    = 2'd0,
    SKIP_COMMENT = 2'd1,
    SKIP_VAR     = 2'd2
  } skip_e;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // Shift command for the scope cell chain.
  typedef struct packed {
    logic   push;
    logic   pop;
    scope_e code;
  } stack_op_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] position;
    logic [15:0] line_count;
  } result_t;

endpackage

[rtl/nsef_cell.sv]
module nsef_cell
  import nsef_pkg::*;
(
  input  logic      clk_i,
  input  stack_op_t op_i,
  input  scope_e    above_i,
  input  scope_e    below_i,
  output scope_e    entry_o
);

  scope_e entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (op_i.push) begin
      entry_d = above_i;
    end else if (op_i.pop) begin
      entry_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[rtl/nsef_stack.sv]
module nsef_stack
  import nsef_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic      clk_i,
  input  stack_op_t op_i,
  output scope_e    top_o
);

  scope_e entry [DEPTH];

  // Cell 0 is the top; push shifts toward higher cells, pop shifts back.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    scope_e above, below;
    if (i == 0) begin : g_first
      assign above = op_i.code;
    end else begin : g_mid
      assign above = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign below = SC_DQ;
    end else begin : g_inner
      assign below = entry[i+1];
    end
    nsef_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op_i),
      .above_i (above),
      .below_i (below),
      .entry_o (entry[i])
    );
  end

  assign top_o = entry[0];

endmodule

[rtl/nsef_parse.sv]
module nsef_parse
  import nsef_pkg::*;
#(
  parameter int unsigned MAX_NESTING = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] text_byte_i,
  input  logic       start_req_i,
  input  scope_e     top_i,
  output stack_op_t  op_o,
  output result_t    result_o
);

  localparam int unsigned LW = $clog2(MAX_NESTING + 1);

  logic [LW-1:0] level_q, level_d;
  logic [7:0]    prev_q, prev_d;
  skip_e         skip_q, skip_d;
  logic          active_q, active_d;
  logic [15:0]   off_q, off_d;
  logic [15:0]   nl_q, nl_d;

  logic   opener;
  scope_e code;
  logic   full;

  always_comb begin
    opener = 1'b1;
    code   = SC_DQ;
    unique case (text_byte_i)
      CH_DQUOTE: code = SC_DQ;
      CH_SQUOTE: code = SC_SQ;
      CH_BTICK:  code = SC_BT;
      CH_LBRACE: code = SC_BR;
      default:   opener = 1'b0;
    endcase
  end

  assign full = (level_q == LW'(MAX_NESTING));

  always_comb begin
    level_d  = level_q;
    prev_d   = prev_q;
    skip_d   = skip_q;
    active_d = active_q;
    off_d    = off_q;
    nl_d     = nl_q;
    op_o     = '{push: 1'b0, pop: 1'b0, code: code};
    result_o = '{status: ST_SCAN, position: '0, line_count: '0};

    if (start_req_i) begin
      level_d  = '0;
      skip_d   = SKIP_NONE;
      off_d    = '0;
      nl_d     = '0;
      active_d = 1'b0;
      if (opener) begin
        op_o.push = 1'b1;
        level_d   = LW'(1);
        prev_d    = text_byte_i;
        active_d  = 1'b1;
      end else begin
        result_o.status = ST_BADOPEN;
      end
    end else if (!active_q) begin
      result_o.status = ST_IDLE;
    end else begin
      if (off_q != CNT_MAX) begin
        off_d = off_q + 16'd1;
      end
      if (text_byte_i == CH_NUL) begin
        result_o.status = ST_ENDED;
      end else begin
        if (text_byte_i == CH_NL && nl_q != CNT_MAX) begin
          nl_d = nl_q + 16'd1;
        end
        if (skip_q == SKIP_COMMENT) begin
          if (text_byte_i == CH_NL) skip_d = SKIP_NONE;
        end else if (skip_q == SKIP_VAR) begin
          if (text_byte_i == CH_RBRACE) skip_d = SKIP_NONE;
        end else if (level_q == '0) begin
          result_o.status = ST_CLOSED;
        end else begin
          case (top_i)
            SC_DQ, SC_SQ: begin
              if (((top_i == SC_DQ && text_byte_i == CH_DQUOTE) ||
                   (top_i == SC_SQ && text_byte_i == CH_SQUOTE)) &&
                  prev_q != CH_BSLASH) begin
                op_o.pop = 1'b1;
                level_d  = level_q - LW'(1);
                if (level_q == LW'(1)) result_o.status = ST_CLOSED;
              end
            end
            SC_BT: begin
              if (text_byte_i == CH_BTICK) begin
                op_o.pop = 1'b1;
                level_d  = level_q - LW'(1);
                if (level_q == LW'(1)) result_o.status = ST_CLOSED;
              end
            end
            default: begin
              if (text_byte_i == CH_HASH) begin
                skip_d = SKIP_COMMENT;
              end else if (text_byte_i == CH_RBRACE) begin
                op_o.pop = 1'b1;
                level_d  = level_q - LW'(1);
                if (level_q == LW'(1)) result_o.status = ST_CLOSED;
              end else if (opener && !(code == SC_BR && prev_q == CH_DOLLAR)) begin
                if (full) begin
                  result_o.status = ST_OVERFLOW;
                end else begin
                  op_o.push = 1'b1;
                  level_d   = level_q + LW'(1);
                end
              end else if (opener) begin
                skip_d = SKIP_VAR;
              end
            end
          endcase
        end
      end
      prev_d              = text_byte_i;
      result_o.position   = off_d;
      result_o.line_count = nl_d;
      if (result_o.status != ST_SCAN) begin
        active_d = 1'b0;
        level_d  = '0;
        skip_d   = SKIP_NONE;
      end
    end

    if (!accept_i) begin
      op_o.push = 1'b0;
      op_o.pop  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= '0;
      prev_q   <= '0;
      skip_q   <= SKIP_NONE;
      active_q <= 1'b0;
      off_q    <= '0;
      nl_q     <= '0;
    end else if (accept_i) begin
      level_q  <= level_d;
      prev_q   <= prev_d;
      skip_q   <= skip_d;
      active_q <= active_d;
      off_q    <= off_d;
      nl_q     <= nl_d;
    end
  end

endmodule

[rtl/nested_scope_end_finder.sv]
// Nested scope end finder. Feed text one byte per transaction on the s_axis
// side; set tuser on the opening byte (double quote, single quote, backtick or
// open brace) to start a search. Every input transaction yields exactly one
// result transaction on m_axis: a status in tuser (scanning, closed here, text
// ended, overflow, bad opener, idle) plus the byte offset from the opener and
// the newline count, both saturating at 65535. Scopes live in a row of
// MAX_NESTING two-bit cells that shift on push and pop, so one byte can
// enter every clock while the skid slot is free. Each result is registered
// into the output register, or into the skid slot while that stalls; this
// two-entry output stage keeps the input open while one result waits.
module nested_scope_end_finder
  import nsef_pkg::*;
#(
  parameter int unsigned MAX_NESTING = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tuser,   // [0] start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] position, [31:16] line_count
  output logic [2:0]  m_axis_tuser    // [2:0] status
);

  logic      accept;
  stack_op_t op;
  scope_e    top;
  result_t   res;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  logic    out_free;
  result_t out_q, skid_q;

  // Take a byte whenever the skid slot is free.
  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  nsef_parse #(
    .MAX_NESTING (MAX_NESTING)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_byte_i (s_axis_tdata),
    .start_req_i (s_axis_tuser),
    .top_i       (top),
    .op_o        (op),
    .result_o    (res)
  );

  nsef_stack #(
    .DEPTH (MAX_NESTING)
  ) u_stack (
    .clk_i (clk_i),
    .op_i  (op),
    .top_o (top)
  );

  // Output register frees up this cycle when empty or being drained.
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    if (out_free) begin
      out_valid_d  = skid_valid_q || accept;
      skid_valid_d = 1'b0;
    end else begin
      out_valid_d  = out_valid_q;
      skid_valid_d = skid_valid_q || accept;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload: drain skid first, else load the fresh result; park it when stalled.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.line_count, out_q.position};
  assign m_axis_tuser  = out_q.status;

endmodule

[rtl/nsef_checker.sv]
`include "nested_scope_end_finder_assert.svh"

module nsef_checker
  import nsef_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  logic        stalled;
  logic        taken;
  logic [34:0] payload;
  logic        quiet_status;
  logic        final_status;

  assign stalled      = m_axis_tvalid && !m_axis_tready;
  assign taken        = s_axis_tvalid && s_axis_tready;
  assign payload      = {m_axis_tuser, m_axis_tdata};
  assign quiet_status = m_axis_tvalid &&
                        ((m_axis_tuser == ST_IDLE) || (m_axis_tuser == ST_BADOPEN));
  assign final_status = m_axis_tvalid &&
                        ((m_axis_tuser == ST_CLOSED) || (m_axis_tuser == ST_ENDED) ||
                         (m_axis_tuser == ST_OVERFLOW));

  `NSEF_ASSERT_NEXT(a_out_hold, stalled, m_axis_tvalid && $stable(payload), "stalled result changed")
  `NSEF_ASSERT_NEXT(a_take_result, taken, m_axis_tvalid, "accepted byte left no result")
  `NSEF_ASSERT(a_stall_has_result, !s_axis_tready |-> m_axis_tvalid, "input stalled, no result")
  `NSEF_ASSERT(a_quiet_zero, quiet_status |-> (m_axis_tdata == 32'd0), "quiet result has counts")
  `NSEF_ASSERT(a_final_pos, final_status |-> (m_axis_tdata[15:0] != 16'd0), "ended at offset zero")

endmodule

bind nested_scope_end_finder nsef_checker u_nsef_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
